### sv/nffe_pkg.sv
// Shared constants, types and codes for the normal flow feature extractor.
package nffe_pkg;

   localparam int FRAME_COLUMNS     = 640;
   localparam int FRAME_ROWS        = 480;
   localparam int MAX_FEATURE_COUNT = 1024;

   localparam int COL_W = $clog2(FRAME_COLUMNS);
   localparam int ROW_W = $clog2(FRAME_ROWS);
   localparam int FCNT_W = $clog2(MAX_FEATURE_COUNT + 1);

   localparam int GRAD_W = 10;  // gradient magnitude, at most 1020
   localparam int PROD_W = 2 * GRAD_W;
   localparam int DIVR_W = 21;  // Sx^2 + Sy^2
   localparam int QUOT_W = 32;
   localparam int ROOT_W = 17;
   localparam int LIM_W  = 18;

   typedef enum logic [1:0] {
      REG_FIRST_ROW = 2'd0,
      REG_END_ROW   = 2'd1,
      REG_LOWER_LIM = 2'd2,
      REG_UPPER_LIM = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CALC,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      U_IDLE,
      U_MUL,
      U_SQR,
      U_DIV,
      U_ROOT
   } unit_state_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] q_x;
      logic [ROOT_W-1:0] q_y;
   } flow_res_type;

endpackage

### sv/nffe_flow_unit.sv
// Iterative flow magnitude unit: products, bit-serial divide and square root.
module nffe_flow_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [nffe_pkg::GRAD_W-1:0] sx_abs,
   input  logic [nffe_pkg::GRAD_W-1:0] sy_abs,
   input  logic [nffe_pkg::GRAD_W-1:0] st_abs,
   output nffe_pkg::flow_res_type    res
);
   import nffe_pkg::*;

   unit_state_type state_ff, state_in;
   logic [4:0]  cnt_ff;
   logic [GRAD_W-1:0] sx_ff, sy_ff, st_ff;
   logic [PROD_W-1:0] px_ff, py_ff;
   logic [DIVR_W-1:0] m_ff;
   logic [DIVR_W-1:0] rem_x_ff, rem_y_ff;
   logic [QUOT_W-1:0] lo_x_ff, lo_y_ff;
   logic [QUOT_W-1:0] root_x_ff, root_y_ff;
   logic [QUOT_W-2:0] bit_ff;
   logic              done_ff;

   logic [2*PROD_W-1:0] sq_x, sq_y;
   logic [DIVR_W:0]     t_x, t_y;
   logic                ge_x, ge_y;
   logic [QUOT_W:0]     rb_x, rb_y;
   logic                rge_x, rge_y;

   assign sq_x  = px_ff * px_ff;
   assign sq_y  = py_ff * py_ff;
   assign t_x   = {rem_x_ff, lo_x_ff[QUOT_W-1]};
   assign t_y   = {rem_y_ff, lo_y_ff[QUOT_W-1]};
   assign ge_x  = t_x >= {1'b0, m_ff};
   assign ge_y  = t_y >= {1'b0, m_ff};
   assign rb_x  = {1'b0, root_x_ff} + {2'b0, bit_ff};
   assign rb_y  = {1'b0, root_y_ff} + {2'b0, bit_ff};
   assign rge_x = {1'b0, lo_x_ff} >= rb_x;
   assign rge_y = {1'b0, lo_y_ff} >= rb_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == U_ROOT) && (cnt_ff == 5'd15);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         U_IDLE: if (start) state_in = U_MUL;
         U_MUL:  state_in = U_SQR;
         U_SQR:  state_in = U_DIV;
         U_DIV:  if (cnt_ff == 5'd31) state_in = U_ROOT;
         U_ROOT: if (cnt_ff == 5'd15) state_in = U_IDLE;
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         U_IDLE: begin
            sx_ff <= sx_abs;
            sy_ff <= sy_abs;
            st_ff <= st_abs;
         end
         U_MUL: begin
            px_ff <= sx_ff * st_ff;
            py_ff <= sy_ff * st_ff;
            m_ff  <= DIVR_W'(sx_ff) * DIVR_W'(sx_ff) + DIVR_W'(sy_ff) * DIVR_W'(sy_ff);
         end
         U_SQR: begin
            // N^2 = (|S||St|)^2 << 12; upper part stays below the divisor
            rem_x_ff <= {1'b0, sq_x[2*PROD_W-1:20]};
            rem_y_ff <= {1'b0, sq_y[2*PROD_W-1:20]};
            lo_x_ff  <= {sq_x[19:0], 12'd0};
            lo_y_ff  <= {sq_y[19:0], 12'd0};
            cnt_ff   <= 5'd0;
         end
         U_DIV: begin
            rem_x_ff <= ge_x ? DIVR_W'(t_x - {1'b0, m_ff}) : t_x[DIVR_W-1:0];
            rem_y_ff <= ge_y ? DIVR_W'(t_y - {1'b0, m_ff}) : t_y[DIVR_W-1:0];
            lo_x_ff  <= {lo_x_ff[QUOT_W-2:0], ge_x};
            lo_y_ff  <= {lo_y_ff[QUOT_W-2:0], ge_y};
            cnt_ff   <= cnt_ff + 5'd1;
            root_x_ff <= '0;
            root_y_ff <= '0;
            bit_ff    <= {1'b1, {(QUOT_W-2){1'b0}}};
         end
         U_ROOT: begin
            if (rge_x) begin
               lo_x_ff   <= lo_x_ff - rb_x[QUOT_W-1:0];
               root_x_ff <= (root_x_ff >> 1) + {1'b0, bit_ff};
            end else begin
               root_x_ff <= root_x_ff >> 1;
            end
            if (rge_y) begin
               lo_y_ff   <= lo_y_ff - rb_y[QUOT_W-1:0];
               root_y_ff <= (root_y_ff >> 1) + {1'b0, bit_ff};
            end else begin
               root_y_ff <= root_y_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 5'd1;
         end
         default: ;
      endcase
   end

   assign res.done = done_ff;
   assign res.q_x  = root_x_ff[ROOT_W-1:0];
   assign res.q_y  = root_y_ff[ROOT_W-1:0];

endmodule

### sv/normal_flow_feature_extractor.sv
// Normal flow feature extractor: line store, window gradients, flow check and output word.
// A pixel giving no word goes from LOAD back to IDLE; a flow candidate waits in CALC for
// the flow unit and in EMIT for a free output slot, and no pixel is accepted outside IDLE; the wait
// is set by the bit-serial divider (32 steps) and square root (16 steps) of that unit.
// Reset: synchronous, clears position, feature count, window and registers to defaults.
// The line store is not cleared; row 0 writes it before any window reads it.
module normal_flow_feature_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pixel_first,
   input  logic [7:0]  req_pixel_second,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_col_start,
   output logic [8:0]  rsp_row_start,
   output logic signed [10:0] rsp_col_end,
   output logic signed [10:0] rsp_row_end,
   output logic [9:0]  rsp_feature_index,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import nffe_pkg::*;

   state_type state_ff, state_in;

   logic [8:0]       first_row_ff, end_row_ff;
   logic signed [LIM_W-1:0] lower_ff, upper_ff;

   logic [15:0] line_store_mem [FRAME_COLUMNS];
   logic [15:0] top_right_ff;
   logic [31:0] window_ff;
   logic [COL_W-1:0] col_ff, cur_col_ff;
   logic [ROW_W-1:0] row_ff, cur_row_ff;
   logic [FCNT_W-1:0] fcnt_ff;
   logic [15:0] cur_ff;
   logic        fs_ff;

   logic        sx_neg_ff, sy_neg_ff;
   logic [GRAD_W-1:0] sxa_ff, sya_ff, sta_ff;
   logic        start_ff;

   logic        rsp_valid_ff;
   logic [9:0]  rsp_col_ff;
   logic [8:0]  rsp_row_ff;
   logic signed [10:0] rsp_cend_ff, rsp_rend_ff;
   logic [9:0]  rsp_idx_ff;

   flow_res_type res;

   logic        accept, cfg_wr;
   logic [COL_W-1:0] rd_col;
   logic [8:0]  a1, a2, b1, b2, c1, c2, d1, d2;
   logic [8:0]  sa, sb, sc, sd;
   logic signed [11:0] sx, sy, st;
   logic [FCNT_W-1:0] fcnt_eff;
   logic signed [11:0] x_s, y_s;
   logic        in_band, in_cols, cand;
   logic signed [LIM_W:0] dx, dy;
   logic        pass, emit;
   logic [7:0]  ox, oy;
   logic [COL_W-1:0] col_next;
   logic [ROW_W-1:0] row_next;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign cfg_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign rd_col = req_frame_start ? '0 : col_ff;

   // configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         first_row_ff <= 9'd0;
         end_row_ff   <= 9'd480;
         lower_ff     <= -18'sd65536;
         upper_ff     <= 18'sd65536;
      end else if (cfg_wr) begin
         unique case (reg_index_type'(paddr[3:2]))
            REG_FIRST_ROW: first_row_ff <= pwdata[8:0];
            REG_END_ROW:   end_row_ff   <= pwdata[8:0];
            REG_LOWER_LIM: lower_ff     <= pwdata[LIM_W-1:0];
            REG_UPPER_LIM: upper_ff     <= pwdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[3:2]))
         REG_FIRST_ROW: prdata = {23'd0, first_row_ff};
         REG_END_ROW:   prdata = {23'd0, end_row_ff};
         REG_LOWER_LIM: prdata = 32'(lower_ff);
         REG_UPPER_LIM: prdata = 32'(upper_ff);
         default:       prdata = '0;
      endcase
   end

   // line store: read on accept, written back in the load cycle
   always_ff @(posedge clock) begin
      if (accept) top_right_ff <= line_store_mem[rd_col];
      if (state_ff == ST_LOAD) line_store_mem[cur_col_ff] <= cur_ff;
   end

   // window gradients
   always_comb begin
      a1 = {1'b0, window_ff[31:24]};
      a2 = {1'b0, window_ff[23:16]};
      b1 = {1'b0, top_right_ff[15:8]};
      b2 = {1'b0, top_right_ff[7:0]};
      c1 = {1'b0, window_ff[15:8]};
      c2 = {1'b0, window_ff[7:0]};
      d1 = {1'b0, cur_ff[15:8]};
      d2 = {1'b0, cur_ff[7:0]};
      sa = a1 + a2;
      sb = b1 + b2;
      sc = c1 + c2;
      sd = d1 + d2;
      sx = $signed({3'd0, sb}) + $signed({3'd0, sd}) - $signed({3'd0, sa})
           - $signed({3'd0, sc});
      sy = $signed({3'd0, sa}) + $signed({3'd0, sb}) - $signed({3'd0, sc})
           - $signed({3'd0, sd});
      st = $signed({3'd0, a2}) + $signed({3'd0, b2}) + $signed({3'd0, c2})
           + $signed({3'd0, d2}) - $signed({3'd0, a1}) - $signed({3'd0, b1})
           - $signed({3'd0, c1}) - $signed({3'd0, d1});
      fcnt_eff = fs_ff ? '0 : fcnt_ff;
      x_s = $signed(12'(cur_col_ff)) - 12'sd1;
      y_s = $signed(12'(cur_row_ff)) - 12'sd1;
      in_band = (y_s >= $signed({3'd0, first_row_ff}) + 12'sd2)
             && (y_s + 12'sd3 < $signed({3'd0, end_row_ff}));
      in_cols = (x_s >= 12'sd2) && (x_s < 12'(FRAME_COLUMNS - 3));
      cand = (cur_col_ff != '0) && (cur_row_ff != '0)
          && !(sx == 12'sd0 && sy == 12'sd0) && in_band && in_cols
          && (fcnt_eff < FCNT_W'(MAX_FEATURE_COUNT));
      col_next = cur_col_ff + COL_W'(1);
      row_next = cur_row_ff;
      if (cur_col_ff == COL_W'(FRAME_COLUMNS - 1)) begin
         col_next = '0;
         row_next = (cur_row_ff == ROW_W'(FRAME_ROWS - 1)) ? '0 : cur_row_ff + ROW_W'(1);
      end
   end

   // flow check and end point
   always_comb begin
      dx = sx_neg_ff ? -$signed({2'b0, res.q_x}) : $signed({2'b0, res.q_x});
      dy = sy_neg_ff ? -$signed({2'b0, res.q_y}) : $signed({2'b0, res.q_y});
      pass = (dx > lower_ff) && (dx < upper_ff) && (dy > lower_ff) && (dy < upper_ff);
      ox = res.q_x[15:8];
      oy = res.q_y[15:8];
      emit = (state_ff == ST_EMIT) && pass && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_LOAD;
         ST_LOAD: state_in = cand ? ST_CALC : ST_IDLE;
         ST_CALC: if (res.done) state_in = ST_EMIT;
         ST_EMIT: if (!pass || emit) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         fcnt_ff      <= '0;
         window_ff    <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= (state_ff == ST_LOAD) && cand;
         if (accept) begin
            cur_ff     <= {req_pixel_first, req_pixel_second};
            fs_ff      <= req_frame_start;
            cur_col_ff <= rd_col;
            cur_row_ff <= req_frame_start ? '0 : row_ff;
         end
         if (state_ff == ST_LOAD) begin
            window_ff <= {top_right_ff, cur_ff};
            col_ff    <= col_next;
            row_ff    <= row_next;
            fcnt_ff   <= fcnt_eff;
            sx_neg_ff <= sx < 0;
            sy_neg_ff <= sy < 0;
            sxa_ff    <= GRAD_W'(sx < 0 ? -sx : sx);
            sya_ff    <= GRAD_W'(sy < 0 ? -sy : sy);
            sta_ff    <= GRAD_W'(st < 0 ? -st : st);
         end
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (emit) begin
            rsp_col_ff   <= 10'(x_s);
            rsp_row_ff   <= 9'(y_s);
            rsp_cend_ff  <= sx_neg_ff ? 11'(x_s) - 11'(ox) : 11'(x_s) + 11'(ox);
            rsp_rend_ff  <= sy_neg_ff ? 11'(y_s) - 11'(oy) : 11'(y_s) + 11'(oy);
            rsp_idx_ff   <= fcnt_ff[9:0];
            fcnt_ff      <= fcnt_ff + FCNT_W'(1);
         end
      end
   end

   nffe_flow_unit u_flow (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .sx_abs (sxa_ff),
      .sy_abs (sya_ff),
      .st_abs (sta_ff),
      .res    (res)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_col_start     = rsp_col_ff;
   assign rsp_row_start     = rsp_row_ff;
   assign rsp_col_end       = rsp_cend_ff;
   assign rsp_row_end       = rsp_rend_ff;
   assign rsp_feature_index = rsp_idx_ff;

`ifndef NO_ASSERTIONS
   a_fcnt_bound: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= FCNT_W'(MAX_FEATURE_COUNT))
      else $error("feature count beyond maximum");
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("word raised outside emit");
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      res.done |-> state_ff == ST_CALC)
      else $error("flow unit finished with no pending window");
`endif

endmodule

### tb/nffe_checker.sv
// Checker for the normal flow feature extractor: tracks registers, predicts words, compares.
`timescale 1ns / 1ps
module nffe_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_pixel_first,
   input  logic [7:0]  req_pixel_second,
   input  logic        req_frame_start,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [9:0]  rsp_col_start,
   input  logic [8:0]  rsp_row_start,
   input  logic [10:0] rsp_col_end,
   input  logic [10:0] rsp_row_end,
   input  logic [9:0]  rsp_feature_index,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          errors,
   output int          pending,
   output int          checked
);
   import nffe_pkg::*;

   typedef struct {
      logic [9:0]  col_start;
      logic [8:0]  row_start;
      logic [10:0] col_end;
      logic [10:0] row_end;
      logic [9:0]  feature_index;
   } feature_word_type;

   feature_word_type feature_q[$];

   logic [15:0]       line_mem [FRAME_COLUMNS];
   logic [31:0]       win;
   int                col_pos, row_pos, feat_cnt;
   logic [8:0]        first_row_r, end_row_r;
   logic signed [17:0] lower_r, upper_r;

   function automatic longint unsigned int_root(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint unsigned flow_mag(int s, int t, longint unsigned m);
      longint unsigned n;
      n = longint'(s) * longint'(t) * 64;
      return int_root((n * n) / m);
   endfunction

   task automatic predict_pixel(logic [7:0] p1, logic [7:0] p2, logic fs);
      logic [15:0]   cur, tr, tl, bl;
      int            c, r, x, y, sa, sb, sc, sd, sx, sy, st;
      longint unsigned m, qx, qy;
      longint        dx, dy, ox, oy;
      feature_word_type w;
      cur = {p1, p2};
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
         feat_cnt = 0;
      end
      c = col_pos;
      r = row_pos;
      tr = line_mem[c];
      tl = win[31:16];
      bl = win[15:0];
      if (c >= 1 && r >= 1) begin
         x = c - 1;
         y = r - 1;
         sa = tl[15:8] + tl[7:0];
         sb = tr[15:8] + tr[7:0];
         sc = bl[15:8] + bl[7:0];
         sd = p1 + p2;
         sx = (sb + sd) - (sa + sc);
         sy = (sa + sb) - (sc + sd);
         st = (tl[7:0] + tr[7:0] + bl[7:0] + p2) - (tl[15:8] + tr[15:8] + bl[15:8] + p1);
         m = longint'(sx * sx) + longint'(sy * sy);
         if (m != 0 && y >= int'(first_row_r) + 2 && y + 3 < int'(end_row_r) &&
             x >= 2 && x < FRAME_COLUMNS - 3 && feat_cnt < MAX_FEATURE_COUNT) begin
            qx = flow_mag(sx < 0 ? -sx : sx, st < 0 ? -st : st, m);
            qy = flow_mag(sy < 0 ? -sy : sy, st < 0 ? -st : st, m);
            dx = sx < 0 ? -longint'(qx) : longint'(qx);
            dy = sy < 0 ? -longint'(qy) : longint'(qy);
            if (dx > lower_r && dx < upper_r && dy > lower_r && dy < upper_r) begin
               ox = sx < 0 ? -longint'(qx >> 8) : longint'(qx >> 8);
               oy = sy < 0 ? -longint'(qy >> 8) : longint'(qy >> 8);
               w.col_start = x[9:0];
               w.row_start = y[8:0];
               w.col_end = 11'(x + ox);
               w.row_end = 11'(y + oy);
               w.feature_index = feat_cnt[9:0];
               feature_q.push_back(w);
               feat_cnt++;
            end
         end
      end
      line_mem[c] = cur;
      win = {tr, cur};
      c++;
      if (c >= FRAME_COLUMNS) begin
         c = 0;
         r++;
         if (r >= FRAME_ROWS) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   task automatic check_word();
      feature_word_type w;
      if (feature_q.size() == 0) begin
         $error("unexpected result word at col %0d row %0d", rsp_col_start, rsp_row_start);
         errors++;
         return;
      end
      w = feature_q.pop_front();
      checked++;
      if (rsp_col_start !== w.col_start) begin
         $error("col_start expected %0d got %0d", w.col_start, rsp_col_start);
         errors++;
      end
      if (rsp_row_start !== w.row_start) begin
         $error("row_start expected %0d got %0d", w.row_start, rsp_row_start);
         errors++;
      end
      if (rsp_col_end !== w.col_end) begin
         $error("col_end expected %0d got %0d", $signed(w.col_end), $signed(rsp_col_end));
         errors++;
      end
      if (rsp_row_end !== w.row_end) begin
         $error("row_end expected %0d got %0d", $signed(w.row_end), $signed(rsp_row_end));
         errors++;
      end
      if (rsp_feature_index !== w.feature_index) begin
         $error("feature_index expected %0d got %0d", w.feature_index, rsp_feature_index);
         errors++;
      end
   endtask

   initial begin
      errors = 0;
      checked = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         feature_q.delete();
         win = '0;
         col_pos = 0;
         row_pos = 0;
         feat_cnt = 0;
         first_row_r = 9'd0;
         end_row_r = 9'd480;
         lower_r = -18'sd65536;
         upper_r = 18'sd65536;
      end else begin
         if (rsp_valid && rsp_ready) check_word();
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[3:2]))
               REG_FIRST_ROW: first_row_r = pwdata[8:0];
               REG_END_ROW:   end_row_r = pwdata[8:0];
               REG_LOWER_LIM: lower_r = pwdata[17:0];
               REG_UPPER_LIM: upper_r = pwdata[17:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_pixel(req_pixel_first, req_pixel_second, req_frame_start);
      end
      pending = feature_q.size();
   end

endmodule

### tb/testbench.sv
// Testbench top: clock, reset, pixel and register stimulus, result sink and verdict.
`timescale 1ns / 1ps
module testbench;
   import nffe_pkg::*;

   logic        clock, reset;
   logic        req_valid, req_ready, req_frame_start;
   logic [7:0]  req_pixel_first, req_pixel_second;
   logic        rsp_valid, rsp_ready;
   logic [9:0]  rsp_col_start, rsp_feature_index;
   logic [8:0]  rsp_row_start;
   logic signed [10:0] rsp_col_end, rsp_row_end;
   logic        psel, penable, pwrite, pready;
   logic [3:0]  paddr;
   logic [31:0] pwdata, prdata;
   int          errors, pending, checked;
   int          words_sent;
   int          pix_col, pix_row;
   bit          idle_on;

   normal_flow_feature_extractor u_top (.*);

   nffe_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_pixel_first, .req_pixel_second,
      .req_frame_start, .rsp_valid, .rsp_ready, .rsp_col_start, .rsp_row_start,
      .rsp_col_end(rsp_col_end), .rsp_row_end(rsp_row_end), .rsp_feature_index,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .errors, .pending, .checked
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // result sink: random stall before each word while idle_on is set
   initial begin
      int gap;
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         gap = idle_on ? $urandom_range(0, 17) : 0;
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic put_word(logic [7:0] a, logic [7:0] b, logic fs);
      int gap;
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_pixel_first <= a;
      req_pixel_second <= b;
      req_frame_start <= fs;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] v);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic set_regs(int fr, int er, int lo, int hi);
      csr_write(REG_FIRST_ROW, fr);
      csr_write(REG_END_ROW, er);
      csr_write(REG_LOWER_LIM, lo);
      csr_write(REG_UPPER_LIM, hi);
      psel <= 0;
      penable <= 0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] clamp8(int v);
      return v < 0 ? 8'd0 : (v > 255 ? 8'd255 : v[7:0]);
   endfunction

   // mode: 0 random, 1 smooth ramp with noise, 2 flat, 3 sparse spikes;
   // the raster position carries on between calls unless a frame starts
   task automatic send_pixels(int npix, int mode, bit with_start, bit keep_idle);
      int base;
      logic [7:0] a, b;
      if (with_start) begin
         pix_col = 0;
         pix_row = 0;
      end
      for (int i = 0; i < npix; i++) begin
         if (i % 64 == 0 && !keep_idle) idle_on = $urandom_range(0, 3) != 0;
         case (mode)
            0: begin
               a = 8'($urandom);
               b = 8'($urandom);
            end
            1: begin
               base = (pix_col * 3 + pix_row * 5) & 255;
               a = clamp8(base + int'($urandom_range(0, 4)) - 2);
               b = clamp8(base + int'($urandom_range(0, 8)) - 4);
            end
            2: begin
               a = 8'd100;
               b = 8'd100;
            end
            default: begin
               a = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'd60;
               b = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'd60;
            end
         endcase
         put_word(a, b, with_start && i == 0);
         pix_col++;
         if (pix_col >= FRAME_COLUMNS) begin
            pix_col = 0;
            pix_row = (pix_row + 1) % FRAME_ROWS;
         end
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_pixel_first = 0;
      req_pixel_second = 0;
      req_frame_start = 0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      words_sent = 0;
      pix_col = 0;
      pix_row = 0;
      idle_on = 1;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes and frame starts mid-row
      put_word(8'd0, 8'd0, 1);
      put_word(8'd255, 8'd255, 0);
      put_word(8'd0, 8'd255, 0);
      put_word(8'd255, 8'd0, 0);
      put_word(8'h55, 8'haa, 0);
      put_word(8'haa, 8'h55, 1);
      put_word(8'd1, 8'd128, 0);
      put_word(8'd128, 8'd1, 0);
      put_word(8'd0, 8'd0, 1);
      put_word(8'd255, 8'd255, 0);
      settle();

      // reset settings: three rows of random content, then windows along the fourth
      send_pixels(FRAME_COLUMNS * 3 + 200, 0, 1, 0);
      settle();
      send_pixels(30, 2, 0, 0);
      settle();

      // narrow band and tight limits
      set_regs(0, 6, -300, 300);
      send_pixels(150, 1, 0, 0);
      settle();

      // band ends before this row, then starts after it: nothing passes
      set_regs(0, 5, -65536, 65536);
      send_pixels(40, 0, 0, 0);
      settle();
      set_regs(1, 480, -65536, 65536);
      send_pixels(40, 3, 0, 0);
      settle();

      // positive components only
      set_regs(0, 480, 0, 65536);
      send_pixels(80, 0, 0, 0);
      settle();

      // widest limits, sparse spikes
      set_regs(0, 511, 32'h0002_0000, 32'h0001_ffff);
      send_pixels(60, 3, 0, 0);
      settle();

      // reset values, no idling, across the end of the row
      idle_on = 0;
      set_regs(0, 480, -65536, 65536);
      send_pixels(80, 0, 0, 1);
      settle();

      $display("sent %0d pixel words over several register settings, checked %0d features",
               words_sent, checked);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
sv/nffe_pkg.sv
sv/nffe_flow_unit.sv
sv/normal_flow_feature_extractor.sv
tb/nffe_checker.sv
tb/testbench.sv
